@@ src/fltw_pkg.sv @@
package fltw_pkg;

   localparam int FUNC_W   = 2;
   localparam int VIRT_W   = 48;
   localparam int PHYS_W   = 52;
   localparam int FLAGS_W  = 12;
   localparam int STATUS_W = 2;
   localparam int FRAME_W  = 40;
   localparam int ENTRY_W  = 64;
   localparam int IDX_W    = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;

   localparam logic [FUNC_W-1:0] FUNC_MAP       = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_UNMAP     = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TRANSLATE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_PAGE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_MAPPED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OUTSIDE    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_PAGE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FREE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_FRAME = 2'd2;

   localparam logic [FLAGS_W-1:0] ENTRY_PRESENT = 12'h001;
   localparam logic [FLAGS_W-1:0] ENTRY_LINK    = 12'h003;

   localparam logic [1:0] LEVEL_LEAF = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_ZERO,
      ST_LINK,
      ST_FINISH
   } state_type;

endpackage

@@ src/fltw_if.sv @@
interface fltw_req_if import fltw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [VIRT_W-1:0]    virt_addr;
   logic [PHYS_W-1:0]    phys_addr;
   logic [FLAGS_W-1:0]   flags;

   modport source (output valid, func, virt_addr, phys_addr, flags, input ready);
   modport sink   (input valid, func, virt_addr, phys_addr, flags, output ready);
endinterface

interface fltw_rsp_if import fltw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [PHYS_W-1:0]    phys_result;
   logic                 tlb_invalidate;

   modport source (output valid, status, phys_result, tlb_invalidate, input ready);
   modport sink   (input valid, status, phys_result, tlb_invalidate, output ready);
endinterface

interface fltw_csr_if import fltw_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ src/fltw_table_store.sv @@
module fltw_table_store import fltw_pkg::*; #(
   parameter int DEPTH = 32768
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH)-1:0]   addr,
   input  logic [ENTRY_W-1:0]         wdata,
   output logic [ENTRY_W-1:0]         rdata
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/four_level_page_table_walker.sv @@
// Four-level page table walker over a local store of TABLE_PAGES table pages
// (512 x 64-bit entries each) held in one single-port RAM with a registered
// read. Each request word maps, unmaps or translates one 4 KiB page (other
// function codes get OK) and gets exactly one response word. A walk of
// existing tables runs from accept via a read and a check state per level for
// the three table levels and the leaf to a finish state that loads the
// response register; each table level a map must create adds a zeroing pass
// over the new page's 512 entries, one entry per cycle, and a link entry
// write, all through the single RAM port. One request is in flight at a time;
// a finished response waits in its output register while the next request is
// accepted. After reset all TABLE_PAGES*512 entries are swept to zero, one
// entry per cycle, while no request is accepted; configuration writes are
// taken at any time and should only be issued while no request is outstanding.
module four_level_page_table_walker import fltw_pkg::*; #(
   parameter int TABLE_PAGES = 64
) (
   input  logic     clock,
   input  logic     reset,
   fltw_req_if.sink   req_ch,
   fltw_rsp_if.source rsp_ch,
   fltw_csr_if.sink   csr_ch
);

   localparam int DEPTH = TABLE_PAGES * 512;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(TABLE_PAGES);
   localparam int NW    = ($clog2(TABLE_PAGES + 1) > 7) ? $clog2(TABLE_PAGES + 1) : 7;
   localparam logic [FRAME_W:0]  TP_WIDE   = (FRAME_W + 1)'(TABLE_PAGES);
   localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);

   state_type state_ff, state_in;

   logic [5:0]          root_ff;
   logic [NW-1:0]       next_free_ff, next_free_in;
   logic [FRAME_W-1:0]  base_ff;

   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [VIRT_W-1:0]   virt_ff, virt_in;
   logic [PHYS_W-1:0]   phys_ff, phys_in;
   logic [FLAGS_W-1:0]  flags_ff, flags_in;

   logic [PW-1:0]       page_ff, page_in;
   logic [PW-1:0]       new_page_ff, new_page_in;
   logic [1:0]          lvl_ff, lvl_in;
   logic [IDX_W-1:0]    zero_cnt_ff, zero_cnt_in;
   logic [AW-1:0]       clear_cnt_ff, clear_cnt_in;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [PHYS_W-1:0]   result_ff, result_in;
   logic                inval_ff, inval_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PHYS_W-1:0]   rsp_result_ff, rsp_result_in;
   logic                rsp_inval_ff, rsp_inval_in;

   logic                mem_we;
   logic [AW-1:0]       mem_addr;
   logic [ENTRY_W-1:0]  mem_wdata;
   logic [ENTRY_W-1:0]  mem_rdata;

   logic                req_fire;
   logic                csr_fire;
   logic                root_inside;
   logic                alloc_ok;
   logic                entry_present;
   logic                entry_inside;
   logic [FRAME_W-1:0]  entry_off;
   logic [IDX_W-1:0]    level_idx;
   logic                rsp_free;

   fltw_table_store #(.DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.phys_result    = rsp_result_ff;
   assign rsp_ch.tlb_invalidate = rsp_inval_ff;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      case (lvl_ff)
         2'd0:    level_idx = virt_ff[47:39];
         2'd1:    level_idx = virt_ff[38:30];
         2'd2:    level_idx = virt_ff[29:21];
         default: level_idx = virt_ff[20:12];
      endcase
   end

   assign root_inside   = (FRAME_W + 1)'(root_ff) < TP_WIDE;
   assign alloc_ok      = (FRAME_W + 1)'(next_free_ff) < TP_WIDE;
   assign entry_present = mem_rdata[0];
   assign entry_off     = mem_rdata[51:12] - base_ff;
   assign entry_inside  = (FRAME_W + 1)'(entry_off) < TP_WIDE;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_cnt_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.func == FUNC_MAP || req_ch.func == FUNC_UNMAP ||
                   req_ch.func == FUNC_TRANSLATE) begin
                  state_in = root_inside ? ST_READ : ST_FINISH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: state_in = ST_CHECK;
         ST_CHECK: begin
            if (lvl_ff == LEVEL_LEAF) begin
               state_in = ST_FINISH;
            end else if (entry_present) begin
               state_in = entry_inside ? ST_READ : ST_FINISH;
            end else if (func_ff == FUNC_MAP && alloc_ok) begin
               state_in = ST_ZERO;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_ZERO: begin
            if (zero_cnt_ff == '1) state_in = ST_LINK;
         end
         ST_LINK: state_in = ST_READ;
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and store control
   always_comb begin
      func_in       = func_ff;
      virt_in       = virt_ff;
      phys_in       = phys_ff;
      flags_in      = flags_ff;
      page_in       = page_ff;
      new_page_in   = new_page_ff;
      lvl_in        = lvl_ff;
      zero_cnt_in   = zero_cnt_ff;
      clear_cnt_in  = clear_cnt_ff;
      next_free_in  = next_free_ff;
      status_in     = status_ff;
      result_in     = result_ff;
      inval_in      = inval_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_result_in = rsp_result_ff;
      rsp_inval_in  = rsp_inval_ff;
      mem_we        = 1'b0;
      mem_addr      = {page_ff, level_idx};
      mem_wdata     = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we       = 1'b1;
            mem_addr     = clear_cnt_ff;
            clear_cnt_in = clear_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_fire) begin
               func_in   = req_ch.func;
               virt_in   = req_ch.virt_addr;
               phys_in   = req_ch.phys_addr;
               flags_in  = req_ch.flags;
               page_in   = PW'(root_ff);
               lvl_in    = 2'd0;
               result_in = '0;
               inval_in  = 1'b0;
               if (req_ch.func == FUNC_MAP || req_ch.func == FUNC_UNMAP ||
                   req_ch.func == FUNC_TRANSLATE) begin
                  status_in = root_inside ? STATUS_OK : STATUS_OUTSIDE;
               end else begin
                  status_in = STATUS_OK;
               end
            end
         end
         ST_CHECK: begin
            if (lvl_ff == LEVEL_LEAF) begin
               if (func_ff == FUNC_MAP) begin
                  mem_we    = 1'b1;
                  mem_wdata = {12'b0, phys_ff[51:12], flags_ff | ENTRY_PRESENT};
                  inval_in  = 1'b1;
               end else if (func_ff == FUNC_UNMAP) begin
                  mem_we   = 1'b1;
                  inval_in = 1'b1;
               end else if (entry_present) begin
                  result_in = {mem_rdata[51:12], virt_ff[11:0]};
               end else begin
                  status_in = STATUS_NOT_MAPPED;
               end
            end else if (entry_present) begin
               if (entry_inside) begin
                  page_in = PW'(entry_off);
                  lvl_in  = lvl_ff + 2'd1;
               end else begin
                  status_in = STATUS_OUTSIDE;
               end
            end else if (func_ff != FUNC_MAP) begin
               status_in = STATUS_NOT_MAPPED;
            end else if (!alloc_ok) begin
               status_in = STATUS_NO_PAGE;
            end else begin
               new_page_in  = PW'(next_free_ff);
               next_free_in = next_free_ff + 1'b1;
               zero_cnt_in  = '0;
            end
         end
         ST_ZERO: begin
            mem_we      = 1'b1;
            mem_addr    = {new_page_ff, zero_cnt_ff};
            zero_cnt_in = zero_cnt_ff + 1'b1;
         end
         ST_LINK: begin
            // the parent entry goes in after the new page is zeroed
            mem_we    = 1'b1;
            mem_wdata = {12'b0, base_ff + FRAME_W'(new_page_ff), ENTRY_LINK};
            page_in   = new_page_ff;
            lvl_in    = lvl_ff + 2'd1;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_result_in = result_ff;
               rsp_inval_in  = inval_ff;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase

      if (csr_fire && csr_ch.index == CSR_FIRST_FREE) begin
         next_free_in = NW'(csr_ch.data[6:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         root_ff      <= '0;
         next_free_ff <= NW'(1);
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         next_free_ff <= next_free_in;
         if (csr_fire && csr_ch.index == CSR_ROOT_PAGE) begin
            root_ff <= csr_ch.data[5:0];
         end
         if (csr_fire && csr_ch.index == CSR_BASE_FRAME) begin
            base_ff <= csr_ch.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      virt_ff       <= virt_in;
      phys_ff       <= phys_in;
      flags_ff      <= flags_in;
      page_ff       <= page_in;
      new_page_ff   <= new_page_in;
      lvl_ff        <= lvl_in;
      zero_cnt_ff   <= zero_cnt_in;
      status_ff     <= status_in;
      result_ff     <= result_in;
      inval_ff      <= inval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_inval_ff  <= rsp_inval_in;
   end

endmodule
